// ===== rtl/core/eop_pkg.sv =====
// Shared types, codes and constants of the EXIF orientation parser.
package eop_pkg;

    localparam int SEG_BYTES = 65536;
    localparam int ADDR_W    = $clog2(SEG_BYTES);

    localparam logic [7:0]  MARK_PREFIX  = 8'hFF;
    localparam logic [7:0]  CODE_SOI     = 8'hD8;
    localparam logic [7:0]  CODE_EOI     = 8'hD9;
    localparam logic [7:0]  CODE_SOS     = 8'hDA;
    localparam logic [7:0]  CODE_APP1    = 8'hE1;
    localparam logic [7:0]  BO_MM        = 8'h4D;
    localparam logic [7:0]  BO_II        = 8'h49;
    localparam logic [7:0]  EXIF_E       = 8'h45;
    localparam logic [7:0]  EXIF_X       = 8'h78;
    localparam logic [7:0]  EXIF_I       = 8'h69;
    localparam logic [7:0]  EXIF_F       = 8'h66;
    localparam logic [7:0]  EXIF_PAD     = 8'h00;
    localparam logic [15:0] TAG_ORIENT   = 16'h0112;
    localparam logic [15:0] TIFF_MAGIC   = 16'd42;
    localparam logic [15:0] EXIF_MIN_LEN = 16'd14;
    localparam logic [15:0] LEN_MIN      = 16'd2;
    localparam logic [15:0] ENTRY_BYTES  = 16'd12;
    localparam logic [15:0] VALUE_OFS    = 16'd8;
    localparam logic [15:0] TIFF_BASE    = 16'd6;
    localparam logic [3:0]  ORIENT_DEF   = 4'd1;
    localparam logic [15:0] ORIENT_MAX   = 16'd8;

    typedef enum logic [14:0] {
        ST_SOI0  = 15'h0001,
        ST_SOI1  = 15'h0002,
        ST_MARK0 = 15'h0004,
        ST_MARK1 = 15'h0008,
        ST_LEN0  = 15'h0010,
        ST_LEN1  = 15'h0020,
        ST_SKIP  = 15'h0040,
        ST_STORE = 15'h0080,
        ST_DRAIN = 15'h0100,
        ST_RD0   = 15'h0200,
        ST_RD1   = 15'h0400,
        ST_RD2   = 15'h0800,
        ST_BOUND = 15'h1000,
        ST_ENTRY = 15'h2000,
        ST_EMIT  = 15'h4000
    } t_state;

    typedef enum logic [9:0] {
        S_EXIF0 = 10'h001,
        S_EXIF1 = 10'h002,
        S_EXIF2 = 10'h004,
        S_ORDER = 10'h008,
        S_MAGIC = 10'h010,
        S_OFF_A = 10'h020,
        S_OFF_B = 10'h040,
        S_COUNT = 10'h080,
        S_TAG   = 10'h100,
        S_VALUE = 10'h200
    } t_step;

    typedef struct packed {
        logic  load_marker;
        logic  load_len_hi;
        logic  load_len;
        logic  cnt_inc;
        logic  store_wr;
        logic  addr_zero;
        logic  addr_inc;
        logic  addr_ifd;
        logic  addr_base;
        logic  addr_value;
        logic  cap_b0;
        logic  set_order;
        logic  load_off_first;
        logic  load_off_second;
        logic  load_count;
        logic  entry_next;
        logic  res_init;
        logic  set_res;
        logic  emit_one;
        logic  emit_res;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic byte_ff;
        logic byte_d8;
        logic byte_end;
        logic len_lt2;
        logic len_eq2;
        logic marker_app1;
        logic cnt_done;
        logic seg_lt14;
        logic hdr_ok;
        logic order_ok;
        logic magic_ok;
        logic off_bad;
        logic entry_end;
        logic tag_match;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/eop_if.sv =====
// Stream interfaces of the parser: file bytes in, orientation codes out.
interface eop_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eop_orient_if;
    logic       valid;
    logic       ready;
    logic [3:0] orientation;

    modport source (output valid, output orientation, input ready);
    modport sink   (input valid, input orientation, output ready);
endinterface

// ===== rtl/core/eop_datapath.sv =====
// Datapath: segment counters, APP1 segment memory, TIFF field checks and result register.
module eop_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  eop_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_byte,
    input  logic            i_out_ready,
    output eop_pkg::t_stat  o_stat,
    output logic            o_out_valid,
    output logic [3:0]      o_orientation
);

    logic [7:0]                 r_marker;
    logic [15:0]                r_seg_len;
    logic [eop_pkg::ADDR_W-1:0] r_cnt;
    logic [eop_pkg::ADDR_W-1:0] r_addr;
    logic [eop_pkg::ADDR_W-1:0] n_addr;
    logic [7:0]                 r_seg_mem [eop_pkg::SEG_BYTES];
    logic [7:0]                 r_rd_byte;
    logic [7:0]                 r_b0;
    logic                       r_big;
    logic [31:0]                r_off;
    logic [15:0]                r_count;
    logic [15:0]                r_idx;
    logic [15:0]                r_base;
    logic [3:0]                 r_res;
    logic                       r_out_valid;
    logic [3:0]                 r_out_data;

    logic [15:0] len_word;
    logic [15:0] pair16;
    logic        hdr_ok;

    assign len_word = {r_seg_len[7:0], i_byte};
    assign pair16   = r_big ? {r_b0, r_rd_byte} : {r_rd_byte, r_b0};

    always_comb begin
        unique case (i_cmd.step)
            eop_pkg::S_EXIF0: hdr_ok = (r_b0 == eop_pkg::EXIF_E) && (r_rd_byte == eop_pkg::EXIF_X);
            eop_pkg::S_EXIF1: hdr_ok = (r_b0 == eop_pkg::EXIF_I) && (r_rd_byte == eop_pkg::EXIF_F);
            eop_pkg::S_EXIF2: hdr_ok = (r_b0 == eop_pkg::EXIF_PAD)
                                       && (r_rd_byte == eop_pkg::EXIF_PAD);
            default:          hdr_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_stat             = '0;
        o_stat.byte_ff     = (i_byte == eop_pkg::MARK_PREFIX);
        o_stat.byte_d8     = (i_byte == eop_pkg::CODE_SOI);
        o_stat.byte_end    = (i_byte == eop_pkg::CODE_EOI) || (i_byte == eop_pkg::CODE_SOS);
        o_stat.len_lt2     = (len_word < eop_pkg::LEN_MIN);
        o_stat.len_eq2     = (len_word == eop_pkg::LEN_MIN);
        o_stat.marker_app1 = (r_marker == eop_pkg::CODE_APP1);
        o_stat.cnt_done    = ({1'b0, r_cnt} + 17'd1) >= {1'b0, r_seg_len};
        o_stat.seg_lt14    = (r_seg_len < eop_pkg::EXIF_MIN_LEN);
        o_stat.hdr_ok      = hdr_ok;
        o_stat.order_ok    = (r_b0 == r_rd_byte)
                             && ((r_b0 == eop_pkg::BO_MM) || (r_b0 == eop_pkg::BO_II));
        o_stat.magic_ok    = (pair16 == eop_pkg::TIFF_MAGIC);
        o_stat.off_bad     = ({1'b0, r_off} + 33'd8) > {17'd0, r_seg_len};
        o_stat.entry_end   = (r_idx >= r_count)
                             || (({1'b0, r_base} + {1'b0, eop_pkg::ENTRY_BYTES})
                                 > {1'b0, r_seg_len});
        o_stat.tag_match   = (pair16 == eop_pkg::TAG_ORIENT);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // Read address: jump to a field, or step through a byte pair.
    always_comb begin
        n_addr = r_addr;
        priority if (i_cmd.addr_zero) begin
            n_addr = '0;
        end else if (i_cmd.addr_ifd) begin
            n_addr = eop_pkg::TIFF_BASE + r_off[15:0];
        end else if (i_cmd.addr_base) begin
            n_addr = r_base;
        end else if (i_cmd.addr_value) begin
            n_addr = r_base + eop_pkg::VALUE_OFS;
        end else if (i_cmd.addr_inc) begin
            n_addr = r_addr + 16'd1;
        end else begin
            n_addr = r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_seg_mem[r_cnt] <= i_byte;
        end
        r_rd_byte <= r_seg_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (i_cmd.load_marker) begin
            r_marker <= i_byte;
        end
        if (i_cmd.load_len_hi) begin
            r_seg_len <= {8'd0, i_byte};
        end
        if (i_cmd.load_len) begin
            r_seg_len <= len_word - eop_pkg::LEN_MIN;
            r_cnt     <= '0;
        end
        if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 16'd1;
        end
        if (i_cmd.cap_b0) begin
            r_b0 <= r_rd_byte;
        end
        if (i_cmd.set_order) begin
            r_big <= (r_b0 == eop_pkg::BO_MM);
        end
        if (i_cmd.load_off_first) begin
            if (r_big) begin
                r_off[31:16] <= pair16;
            end else begin
                r_off[15:0] <= pair16;
            end
        end
        if (i_cmd.load_off_second) begin
            if (r_big) begin
                r_off[15:0] <= pair16;
            end else begin
                r_off[31:16] <= pair16;
            end
        end
        if (i_cmd.load_count) begin
            r_count <= pair16;
            r_base  <= r_addr;
            r_idx   <= '0;
        end
        if (i_cmd.entry_next) begin
            r_idx  <= r_idx + 16'd1;
            r_base <= r_base + eop_pkg::ENTRY_BYTES;
        end
        if (i_cmd.res_init) begin
            r_res <= eop_pkg::ORIENT_DEF;
        end
        if (i_cmd.set_res) begin
            r_res <= ((pair16 != 16'd0) && (pair16 <= eop_pkg::ORIENT_MAX))
                     ? pair16[3:0] : eop_pkg::ORIENT_DEF;
        end
        if (i_cmd.emit_one) begin
            r_out_data <= eop_pkg::ORIENT_DEF;
        end else if (i_cmd.emit_res) begin
            r_out_data <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_one || i_cmd.emit_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_orientation = r_out_data;

`ifndef SYNTHESIS
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data != 4'd0) && ({12'd0, r_out_data} <= eop_pkg::ORIENT_MAX))
        else $error("orientation code out of range");

    a_store_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_wr |-> ({1'b0, r_cnt} < {1'b0, r_seg_len}))
        else $error("segment store write past segment length");

    a_value_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.addr_value |-> (({1'b0, r_base} + {1'b0, eop_pkg::ENTRY_BYTES})
                              <= {1'b0, r_seg_len}))
        else $error("entry value read outside segment");
`endif

endmodule

// ===== rtl/core/eop_ctrl.sv =====
// Controller: segment walk state machine and IFD0 scan sequencer.
module eop_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last,
    output logic            o_ready,
    input  eop_pkg::t_stat  i_stat,
    output eop_pkg::t_cmd   o_cmd
);

    eop_pkg::t_state r_state, n_state;
    eop_pkg::t_step  r_step, n_step;
    logic            r_last, n_last;

    logic parse_st;
    logic fire;
    logic give;
    logic eval;
    logic rd2_seen;

    assign parse_st = (r_state == eop_pkg::ST_SOI0) || (r_state == eop_pkg::ST_SOI1)
                   || (r_state == eop_pkg::ST_MARK0) || (r_state == eop_pkg::ST_MARK1)
                   || (r_state == eop_pkg::ST_LEN0) || (r_state == eop_pkg::ST_LEN1)
                   || (r_state == eop_pkg::ST_SKIP) || (r_state == eop_pkg::ST_STORE)
                   || (r_state == eop_pkg::ST_DRAIN);
    assign o_ready  = parse_st && i_stat.out_free;
    assign fire     = i_valid && o_ready;
    assign rd2_seen = (r_state == eop_pkg::ST_RD2);

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_last   = r_last;
        give     = 1'b0;
        eval     = 1'b0;
        o_cmd      = '0;
        o_cmd.step = r_step;

        unique case (r_state)
            eop_pkg::ST_SOI0: begin
                if (fire) begin
                    if (!i_stat.byte_ff) give = 1'b1;
                    else n_state = eop_pkg::ST_SOI1;
                end
            end
            eop_pkg::ST_SOI1: begin
                if (fire) begin
                    if (!i_stat.byte_d8) give = 1'b1;
                    else n_state = eop_pkg::ST_MARK0;
                end
            end
            eop_pkg::ST_MARK0: begin
                if (fire) begin
                    if (!i_stat.byte_ff) give = 1'b1;
                    else n_state = eop_pkg::ST_MARK1;
                end
            end
            eop_pkg::ST_MARK1: begin
                if (fire) begin
                    o_cmd.load_marker = 1'b1;
                    if (i_stat.byte_end) give = 1'b1;
                    else n_state = eop_pkg::ST_LEN0;
                end
            end
            eop_pkg::ST_LEN0: begin
                if (fire) begin
                    o_cmd.load_len_hi = 1'b1;
                    n_state = eop_pkg::ST_LEN1;
                end
            end
            eop_pkg::ST_LEN1: begin
                if (fire) begin
                    if (i_stat.len_lt2) begin
                        give = 1'b1;
                    end else begin
                        o_cmd.load_len = 1'b1;
                        if (!i_stat.marker_app1) begin
                            n_state = i_stat.len_eq2 ? eop_pkg::ST_MARK0 : eop_pkg::ST_SKIP;
                        end else if (i_stat.len_eq2) begin
                            give = 1'b1;
                        end else begin
                            n_state = eop_pkg::ST_STORE;
                        end
                    end
                end
            end
            eop_pkg::ST_SKIP: begin
                if (fire) begin
                    o_cmd.cnt_inc = 1'b1;
                    if (i_stat.cnt_done) n_state = eop_pkg::ST_MARK0;
                end
            end
            eop_pkg::ST_STORE: begin
                if (fire) begin
                    o_cmd.store_wr = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    if (i_stat.cnt_done) begin
                        if (i_stat.seg_lt14) begin
                            give = 1'b1;
                        end else begin
                            eval            = 1'b1;
                            o_cmd.res_init  = 1'b1;
                            o_cmd.addr_zero = 1'b1;
                            n_step  = eop_pkg::S_EXIF0;
                            n_state = eop_pkg::ST_RD0;
                            n_last  = i_last;
                        end
                    end
                end
            end
            eop_pkg::ST_DRAIN: begin
                // drop bytes until the file ends
            end
            eop_pkg::ST_RD0: begin
                o_cmd.addr_inc = 1'b1;
                n_state = eop_pkg::ST_RD1;
            end
            eop_pkg::ST_RD1: begin
                o_cmd.addr_inc = 1'b1;
                o_cmd.cap_b0   = 1'b1;
                n_state = eop_pkg::ST_RD2;
            end
            eop_pkg::ST_RD2: begin
                n_state = eop_pkg::ST_RD0;
                unique case (r_step)
                    eop_pkg::S_EXIF0: begin
                        if (!i_stat.hdr_ok) n_state = eop_pkg::ST_EMIT;
                        else n_step = eop_pkg::S_EXIF1;
                    end
                    eop_pkg::S_EXIF1: begin
                        if (!i_stat.hdr_ok) n_state = eop_pkg::ST_EMIT;
                        else n_step = eop_pkg::S_EXIF2;
                    end
                    eop_pkg::S_EXIF2: begin
                        if (!i_stat.hdr_ok) n_state = eop_pkg::ST_EMIT;
                        else n_step = eop_pkg::S_ORDER;
                    end
                    eop_pkg::S_ORDER: begin
                        if (!i_stat.order_ok) begin
                            n_state = eop_pkg::ST_EMIT;
                        end else begin
                            o_cmd.set_order = 1'b1;
                            n_step = eop_pkg::S_MAGIC;
                        end
                    end
                    eop_pkg::S_MAGIC: begin
                        if (!i_stat.magic_ok) n_state = eop_pkg::ST_EMIT;
                        else n_step = eop_pkg::S_OFF_A;
                    end
                    eop_pkg::S_OFF_A: begin
                        o_cmd.load_off_first = 1'b1;
                        n_step = eop_pkg::S_OFF_B;
                    end
                    eop_pkg::S_OFF_B: begin
                        o_cmd.load_off_second = 1'b1;
                        n_state = eop_pkg::ST_BOUND;
                    end
                    eop_pkg::S_COUNT: begin
                        o_cmd.load_count = 1'b1;
                        n_state = eop_pkg::ST_ENTRY;
                    end
                    eop_pkg::S_TAG: begin
                        if (i_stat.tag_match) begin
                            o_cmd.addr_value = 1'b1;
                            n_step = eop_pkg::S_VALUE;
                        end else begin
                            o_cmd.entry_next = 1'b1;
                            n_state = eop_pkg::ST_ENTRY;
                        end
                    end
                    eop_pkg::S_VALUE: begin
                        o_cmd.set_res = 1'b1;
                        n_state = eop_pkg::ST_EMIT;
                    end
                    default: begin
                        n_state = eop_pkg::ST_EMIT;
                    end
                endcase
            end
            eop_pkg::ST_BOUND: begin
                if (i_stat.off_bad) begin
                    n_state = eop_pkg::ST_EMIT;
                end else begin
                    o_cmd.addr_ifd = 1'b1;
                    n_step  = eop_pkg::S_COUNT;
                    n_state = eop_pkg::ST_RD0;
                end
            end
            eop_pkg::ST_ENTRY: begin
                if (i_stat.entry_end) begin
                    n_state = eop_pkg::ST_EMIT;
                end else begin
                    o_cmd.addr_base = 1'b1;
                    n_step  = eop_pkg::S_TAG;
                    n_state = eop_pkg::ST_RD0;
                end
            end
            eop_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_res = 1'b1;
                    n_state = r_last ? eop_pkg::ST_SOI0 : eop_pkg::ST_DRAIN;
                end
            end
            default: begin
                n_state = eop_pkg::ST_DRAIN;
            end
        endcase

        // One result per file: at the deciding byte, or at the last byte.
        if (fire && !eval) begin
            if (i_last) begin
                if (r_state != eop_pkg::ST_DRAIN) o_cmd.emit_one = 1'b1;
                n_state = eop_pkg::ST_SOI0;
            end else if (give) begin
                o_cmd.emit_one = 1'b1;
                n_state = eop_pkg::ST_DRAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eop_pkg::ST_SOI0;
            r_step  <= eop_pkg::S_EXIF0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_last  <= n_last;
        end
    end

`ifndef SYNTHESIS
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_one || o_cmd.emit_res) |-> i_stat.out_free)
        else $error("result issued while output register is held");

    a_no_take_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd2_seen || (r_state == eop_pkg::ST_ENTRY) || (r_state == eop_pkg::ST_EMIT))
        |-> !o_ready)
        else $error("input taken during IFD scan");

    a_emit_ends_file: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_res |=> (r_state == eop_pkg::ST_SOI0) || (r_state == eop_pkg::ST_DRAIN))
        else $error("scan result not followed by drain or rearm");
`endif

endmodule

// ===== rtl/core/exif_orientation_parser_unit.sv =====
// Top level of the EXIF orientation parser: byte stream in, one orientation per file out.
//
//  channel  dir  transfer payload                   meaning
//  i_in     in   data_byte[7:0], last_byte          one JPEG file byte, last_byte ends the file
//  o_out    out  orientation[3:0]                   EXIF orientation 1..8, 1 when absent
//
// Flow: one byte per cycle while walking markers and segments, unless a held result
//   blocks new bytes. At the end of the first APP1 segment, if it holds at least 14
//   bytes, the IFD0 scan reads the segment memory through its single read port, two
//   bytes at a time, looking at IFD0 entries in turn until one holds the tag; no byte
//   is taken during the scan or while it waits for the output register.
// Reset: synchronous, active low; clears the controller and the output valid. The
//   segment memory is not cleared: only bytes of the current segment are read back.
// Stalls: a held result blocks new bytes only when it is not taken in the same cycle.
module exif_orientation_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    eop_byte_if.sink           i_in,
    eop_orient_if.source       o_out
);

    eop_pkg::t_cmd  ctl_cmd;
    eop_pkg::t_stat dp_stat;
    logic           ctl_ready;
    logic           dp_out_valid;
    logic [3:0]     dp_orientation;

    // Controller: walks the segments and sequences the IFD0 scan.
    eop_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_last  (i_in.last_byte),
        .o_ready (ctl_ready),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd)
    );

    // Datapath: counters, segment memory, field checks, result register.
    eop_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctl_cmd),
        .i_byte        (i_in.data_byte),
        .i_out_ready   (o_out.ready),
        .o_stat        (dp_stat),
        .o_out_valid   (dp_out_valid),
        .o_orientation (dp_orientation)
    );

    // Hold the result in the output register until the sink takes it.
    assign i_in.ready        = ctl_ready;
    assign o_out.valid       = dp_out_valid;
    assign o_out.orientation = dp_orientation;

endmodule
